// ===== hdl/ethernet_ipv4_header_classifier_macros.svh =====
// Assertion shorthands for the header classifier checker.
`ifndef ETHERNET_IPV4_HEADER_CLASSIFIER_MACROS_SVH
`define ETHERNET_IPV4_HEADER_CLASSIFIER_MACROS_SVH

// Same-cycle implication, disabled while in reset.
`define EHC_ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("ehc check failed");

// Next-cycle implication, disabled while in reset.
`define EHC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("ehc check failed");

`endif

// ===== hdl/ehc_pkg.sv =====
`default_nettype none

package ehc_pkg;

	localparam int MAX_FRAME_BYTES_DEF = 65535;
	localparam int IDX_W               = 16;
	localparam int HDR_W               = 8;

	// Frame positions
	localparam logic [IDX_W-1:0] POS_SRC_MAC   = 16'd6;
	localparam logic [IDX_W-1:0] POS_ETYPE     = 16'd12;
	localparam logic [IDX_W-1:0] POS_IHL       = 16'd14;
	localparam logic [IDX_W-1:0] POS_TTL       = 16'd22;
	localparam logic [IDX_W-1:0] POS_PROTO     = 16'd23;
	localparam logic [IDX_W-1:0] POS_SRC_IP    = 16'd26;
	localparam logic [IDX_W-1:0] POS_DST_IP    = 16'd30;
	localparam logic [IDX_W-1:0] ETH_HDR_BYTES = 16'd14;

	// Offsets inside the layer-4 header
	localparam logic [IDX_W-1:0] L4_OFF_P1_HI  = 16'd0;
	localparam logic [IDX_W-1:0] L4_OFF_P1_LO  = 16'd1;
	localparam logic [IDX_W-1:0] L4_OFF_P2_HI  = 16'd2;
	localparam logic [IDX_W-1:0] L4_OFF_P2_LO  = 16'd3;
	localparam logic [IDX_W-1:0] L4_OFF_DOFF   = 16'd12;
	localparam logic [IDX_W-1:0] L4_OFF_FLAGS  = 16'd13;

	localparam logic [HDR_W-1:0] L4_FIXED_BYTES = 8'd8;

	localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
	localparam logic [7:0]  PROTO_ICMP     = 8'd1;
	localparam logic [7:0]  PROTO_TCP      = 8'd6;
	localparam logic [7:0]  PROTO_UDP      = 8'd17;

	localparam logic [2:0] CLASS_TCP    = 3'd0;
	localparam logic [2:0] CLASS_UDP    = 3'd1;
	localparam logic [2:0] CLASS_ICMP   = 3'd2;
	localparam logic [2:0] CLASS_OTHER  = 3'd3;
	localparam logic [2:0] CLASS_NON_IP = 3'd4;

	typedef struct packed {
		logic [7:0] frame_byte;
		logic       last_byte;
	} in_item_t;

	typedef struct packed {
		logic [2:0]  proto_class;
		logic [7:0]  ip_protocol;
		logic [47:0] dst_mac;
		logic [47:0] src_mac;
		logic [31:0] src_ip;
		logic [31:0] dst_ip;
		logic [7:0]  ttl;
		logic [15:0] src_port_or_type;
		logic [15:0] dst_port_or_code;
		logic [5:0]  tcp_flags;
		logic [15:0] frame_length;
		logic [15:0] payload_length;
	} out_item_t;

	typedef struct packed {
		logic [IDX_W-1:0] byte_index;
		logic [47:0]      dst_mac;
		logic [47:0]      src_mac;
		logic [15:0]      ethertype;
		logic [3:0]       ihl;
		logic [7:0]       ttl;
		logic [7:0]       proto;
		logic [31:0]      src_ip;
		logic [31:0]      dst_ip;
		logic [15:0]      port1;
		logic [15:0]      port2;
		logic [3:0]       doff;
		logic [5:0]       flags;
	} hdr_state_t;

endpackage

`default_nettype wire

// ===== hdl/ehc_stream_if.sv =====
`default_nettype none

interface ehc_stream_if #(parameter type data_t = logic);
	logic  valid;
	logic  ready;
	data_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== hdl/ehc_capture.sv =====
`default_nettype none

module ehc_capture #(
	parameter int MAX_FRAME_BYTES = ehc_pkg::MAX_FRAME_BYTES_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               step,
	input  wire logic [7:0]         frame_byte,
	input  wire logic               last_byte,
	output ehc_pkg::hdr_state_t     state_nxt
);

	ehc_pkg::hdr_state_t             state_q;
	logic [ehc_pkg::IDX_W-1:0]       pos;
	logic [3:0]                      ihl_eff;
	logic [ehc_pkg::IDX_W-1:0]       l4_start;
	logic [ehc_pkg::IDX_W-1:0]       l4_off;

	assign pos      = state_q.byte_index;
	// the header-length byte places the layer-4 header by its own value
	assign ihl_eff  = (pos == ehc_pkg::POS_IHL) ? frame_byte[3:0] : state_q.ihl;
	assign l4_start = ehc_pkg::ETH_HDR_BYTES + {10'd0, ihl_eff, 2'b00};
	assign l4_off   = pos - l4_start;

	always_comb begin
		state_nxt = state_q;
		if (pos < ehc_pkg::IDX_W'(MAX_FRAME_BYTES)) begin
			state_nxt.byte_index = pos + 1'b1;
			for (int i = 0; i < 6; i++) begin
				if (pos == ehc_pkg::IDX_W'(i))
					state_nxt.dst_mac[8*(5-i) +: 8] = frame_byte;
				if (pos == ehc_pkg::POS_SRC_MAC + ehc_pkg::IDX_W'(i))
					state_nxt.src_mac[8*(5-i) +: 8] = frame_byte;
			end
			for (int i = 0; i < 2; i++) begin
				if (pos == ehc_pkg::POS_ETYPE + ehc_pkg::IDX_W'(i))
					state_nxt.ethertype[8*(1-i) +: 8] = frame_byte;
			end
			for (int i = 0; i < 4; i++) begin
				if (pos == ehc_pkg::POS_SRC_IP + ehc_pkg::IDX_W'(i))
					state_nxt.src_ip[8*(3-i) +: 8] = frame_byte;
				if (pos == ehc_pkg::POS_DST_IP + ehc_pkg::IDX_W'(i))
					state_nxt.dst_ip[8*(3-i) +: 8] = frame_byte;
			end
			if (pos == ehc_pkg::POS_IHL)
				state_nxt.ihl = frame_byte[3:0];
			if (pos == ehc_pkg::POS_TTL)
				state_nxt.ttl = frame_byte;
			if (pos == ehc_pkg::POS_PROTO)
				state_nxt.proto = frame_byte;
			if (pos >= l4_start) begin
				unique case (l4_off)
					ehc_pkg::L4_OFF_P1_HI: state_nxt.port1[15:8] = frame_byte;
					ehc_pkg::L4_OFF_P1_LO: state_nxt.port1[7:0]  = frame_byte;
					ehc_pkg::L4_OFF_P2_HI: state_nxt.port2[15:8] = frame_byte;
					ehc_pkg::L4_OFF_P2_LO: state_nxt.port2[7:0]  = frame_byte;
					ehc_pkg::L4_OFF_DOFF:  state_nxt.doff = frame_byte[7:4];
					ehc_pkg::L4_OFF_FLAGS: begin
						// reorder to URG PSH RST FIN ACK SYN
						state_nxt.flags = {frame_byte[5], frame_byte[3], frame_byte[2],
							frame_byte[0], frame_byte[4], frame_byte[1]};
					end
					default: ;
				endcase
			end
		end
	end

	// clear after the last byte so the next frame starts clean
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (step) begin
			state_q <= last_byte ? '0 : state_nxt;
		end
	end

endmodule

`default_nettype wire

// ===== hdl/ehc_classify.sv =====
`default_nettype none

module ehc_classify (
	input  ehc_pkg::hdr_state_t state,
	output ehc_pkg::out_item_t  result
);

	logic [ehc_pkg::HDR_W-1:0] hdr_len;
	logic [15:0]               hdr_ext;

	always_comb begin
		result              = '0;
		result.dst_mac      = state.dst_mac;
		result.src_mac      = state.src_mac;
		result.frame_length = state.byte_index;
		hdr_len             = ehc_pkg::HDR_W'(ehc_pkg::ETH_HDR_BYTES);
		if (state.ethertype == ehc_pkg::ETHERTYPE_IPV4) begin
			result.ip_protocol = state.proto;
			result.src_ip      = state.src_ip;
			result.dst_ip      = state.dst_ip;
			result.ttl         = state.ttl;
			hdr_len            = hdr_len + {2'b00, state.ihl, 2'b00};
			case (state.proto)
				ehc_pkg::PROTO_TCP: begin
					result.proto_class      = ehc_pkg::CLASS_TCP;
					result.src_port_or_type = state.port1;
					result.dst_port_or_code = state.port2;
					result.tcp_flags        = state.flags;
					hdr_len                 = hdr_len + {2'b00, state.doff, 2'b00};
				end
				ehc_pkg::PROTO_UDP: begin
					result.proto_class      = ehc_pkg::CLASS_UDP;
					result.src_port_or_type = state.port1;
					result.dst_port_or_code = state.port2;
					hdr_len                 = hdr_len + ehc_pkg::L4_FIXED_BYTES;
				end
				ehc_pkg::PROTO_ICMP: begin
					result.proto_class      = ehc_pkg::CLASS_ICMP;
					result.src_port_or_type = {8'd0, state.port1[15:8]};
					result.dst_port_or_code = {8'd0, state.port1[7:0]};
					hdr_len                 = hdr_len + ehc_pkg::L4_FIXED_BYTES;
				end
				default: result.proto_class = ehc_pkg::CLASS_OTHER;
			endcase
		end else begin
			result.proto_class = ehc_pkg::CLASS_NON_IP;
		end
		hdr_ext = {8'd0, hdr_len};
		// clamp at zero on short frames
		result.payload_length = (state.byte_index > hdr_ext) ?
			(state.byte_index - hdr_ext) : 16'd0;
	end

endmodule

`default_nettype wire

// ===== hdl/ethernet_ipv4_header_classifier.sv =====
// Ethernet / IPv4 / layer-4 header classifier.
// Channels: 'frame' is a valid/ready sink of one frame byte per transfer, with
// last_byte marking the final byte of each frame. 'summary' is a valid/ready
// source carrying one classification per frame: class, MACs, IPv4 fields,
// ports or ICMP type/code, TCP flags, frame length and payload length.
// Throughput: one byte per clock unless a last byte waits on a full summary
// register (see Stall); frames go back to back with no gap. The last byte of
// a frame is taken into the input register, then a single pass of capture
// and classify logic writes the result register.
// Stall: a pending summary is held until taken. Bytes keep flowing while the
// summary waits; only a further last byte stalls the input until the summary
// register frees up (it may free in the same cycle).
// Reset: arst_n clears the input and result valid flags and all capture state;
// the first byte after reset is byte 0 of a new frame.
// Bytes beyond MAX_FRAME_BYTES are neither counted nor captured.
`default_nettype none

module ethernet_ipv4_header_classifier #(
	parameter int MAX_FRAME_BYTES = ehc_pkg::MAX_FRAME_BYTES_DEF
) (
	input  wire logic     clk,
	input  wire logic     arst_n,
	ehc_stream_if.sink    frame,
	ehc_stream_if.source  summary
);

	// input register
	logic                valid_s1;
	logic [7:0]          byte_s1;
	logic                last_s1;

	// result register
	logic                out_valid_q;
	ehc_pkg::out_item_t  out_data_q;

	logic                advance;
	logic                step;
	ehc_pkg::hdr_state_t state_nxt;
	ehc_pkg::out_item_t  result;

	// hold a last byte only while the summary register is full and not taken
	assign advance     = !(last_s1 && out_valid_q && !summary.ready);
	assign step        = valid_s1 && advance;
	assign frame.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (frame.ready) begin
			valid_s1 <= frame.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (frame.ready) begin
			byte_s1 <= frame.data.frame_byte;
			last_s1 <= frame.data.last_byte;
		end
	end

	ehc_capture #(
		.MAX_FRAME_BYTES (MAX_FRAME_BYTES)
	) u_capture (
		.clk        (clk),
		.arst_n     (arst_n),
		.step       (step),
		.frame_byte (byte_s1),
		.last_byte  (last_s1),
		.state_nxt  (state_nxt)
	);

	// classify from the state including the last byte itself
	ehc_classify u_classify (
		.state  (state_nxt),
		.result (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (step && last_s1) begin
			out_valid_q <= 1'b1;
		end else if (summary.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step && last_s1) begin
			out_data_q <= result;
		end
	end

	assign summary.valid = out_valid_q;
	assign summary.data  = out_data_q;

endmodule

`default_nettype wire

// ===== hdl/ehc_checker.sv =====
`default_nettype none
`include "ethernet_ipv4_header_classifier_macros.svh"

module ehc_checker (
	input wire logic               clk,
	input wire logic               arst_n,
	input wire logic               out_valid,
	input wire logic               out_ready,
	input ehc_pkg::out_item_t      out_data
);

	`EHC_ASSERT_NEXT(a_summary_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(out_data))
	`EHC_ASSERT_SAME(a_payload_in_frame, clk, arst_n, out_valid, out_data.payload_length <= out_data.frame_length)
	`EHC_ASSERT_SAME(a_non_ip_zero, clk, arst_n, out_valid && out_data.proto_class == ehc_pkg::CLASS_NON_IP, out_data.ip_protocol == 8'd0 && out_data.src_ip == 32'd0 && out_data.dst_ip == 32'd0 && out_data.ttl == 8'd0 && out_data.src_port_or_type == 16'd0)
	`EHC_ASSERT_SAME(a_flags_tcp_only, clk, arst_n, out_valid && out_data.proto_class != ehc_pkg::CLASS_TCP, out_data.tcp_flags == 6'd0)

endmodule

bind ethernet_ipv4_header_classifier ehc_checker u_ehc_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (summary.valid),
	.out_ready (summary.ready),
	.out_data  (summary.data)
);

`default_nettype wire
